@@ design/assert_macros.svh @@
// Assertion helpers used by the display module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tsd_pkg.sv @@
package tsd_pkg;

   localparam int GLYPH_WIDTH     = 5;
   localparam int TEMP_WIDTH      = 16;
   localparam int ENABLE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int DIVIDER_WIDTH   = 8;
   localparam int PERIOD_WIDTH    = 16;

   localparam logic [GLYPH_WIDTH-1:0] GLYPH_ONE        = 5'd1;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_BLANK      = 5'd10;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_MINUS      = 5'd11;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_DEGREE     = 5'd12;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_UNDERSCORE = 5'd13;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFRESH_DIVIDER = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_PERIOD    = 4'd1;

   localparam logic [DIVIDER_WIDTH-1:0] REFRESH_DIVIDER_RESET = 8'd100;
   localparam logic [PERIOD_WIDTH-1:0]  BLINK_PERIOD_RESET    = 16'd1000;

   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_TEMPERATURE = 2'd1,
      OP_GLYPHS      = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_KEEP   = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_STEADY = 2'd2,
      MODE_DARK   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [GLYPH_WIDTH-1:0] left;
      logic [GLYPH_WIDTH-1:0] middle;
      logic [GLYPH_WIDTH-1:0] right;
   } glyph_set_type;

   typedef struct packed {
      logic [ENABLE_WIDTH-1:0] digit_enable;
      logic [GLYPH_WIDTH-1:0]  segment_glyph;
      logic                    visible;
   } result_type;

   // Tens and units of a remainder below one hundred, packed as two nibbles.
   typedef logic [7:0] digit_pair_table_type [128];

   function automatic digit_pair_table_type build_digit_pairs();
      digit_pair_table_type table_out;
      logic [3:0] tens;
      logic [3:0] units;
      tens  = 4'd0;
      units = 4'd0;
      for (int i = 0; i < 128; i++) begin
         table_out[i] = (i < 100) ? {tens, units} : 8'd0;
         if (units == 4'd9) begin
            units = 4'd0;
            tens  = tens + 4'd1;
         end else begin
            units = units + 4'd1;
         end
      end
      return table_out;
   endfunction

   localparam digit_pair_table_type DIGIT_PAIRS = build_digit_pairs();

endpackage

@@ design/tsd_req_if.sv @@
interface tsd_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic signed [tsd_pkg::TEMP_WIDTH-1:0] temp_raw;
   logic                                low_resolution;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]     glyph_left;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]     glyph_middle;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]     glyph_right;
   logic [1:0]                          display_mode;

   modport source (
      output valid, operation, temp_raw, low_resolution,
             glyph_left, glyph_middle, glyph_right, display_mode,
      input  ready
   );
   modport sink (
      input  valid, operation, temp_raw, low_resolution,
             glyph_left, glyph_middle, glyph_right, display_mode,
      output ready
   );
endinterface

@@ design/tsd_rsp_if.sv @@
interface tsd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tsd_pkg::ENABLE_WIDTH-1:0]    digit_enable;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]     segment_glyph;
   logic                                visible;

   modport source (
      output valid, digit_enable, segment_glyph, visible,
      input  ready
   );
   modport sink (
      input  valid, digit_enable, segment_glyph, visible,
      output ready
   );
endinterface

@@ design/tsd_csr_if.sv @@
interface tsd_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tsd_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [tsd_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/temperature_seven_segment_display.sv @@
// Multiplexed seven-segment temperature display, driven by glyph codes.
// req carries one beat per command: a tick from the free-running timer, a
// raw temperature word to show, or three glyphs to write directly, each with
// an optional display mode (keep, blink, steady, dark).
// rsp returns one beat per request: the digit drive lines, the glyph on the
// segment port and the visibility flag, as they stand after that request.
// csr writes the refresh divider (index 0) and the blink period (index 1);
// it is always ready; the user writes it only while the block is idle, as the
// block does not enforce this. Throughput is one request per clock while
// req_ready is high: every command updates the state in the cycle it is
// accepted, and the temperature conversion (one constant reciprocal multiply
// and a digit table) fits in that cycle. The registered response follows in
// the next cycle when rsp is ready. A two-beat output stage (output and skid
// registers) lets the block take a request while a response waits; req_ready
// drops only when both are full, and rises again as soon as rsp takes a beat.
// Reset is synchronous: registers return to divider 100, period 1000,
// display shown without blinking, underscore on the left digit, drive off.
`include "assert_macros.svh"

module temperature_seven_segment_display #(
   parameter int DIGIT_COUNT = 3
) (
   input logic       clock,
   input logic       reset,
   tsd_req_if.sink   req,
   tsd_rsp_if.source rsp,
   tsd_csr_if.sink   csr
);

   localparam int POS_WIDTH = $clog2(DIGIT_COUNT);
   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGIT_COUNT - 1);

   logic [tsd_pkg::DIVIDER_WIDTH-1:0] refresh_divider_ff, refresh_divider_in;
   logic [tsd_pkg::PERIOD_WIDTH-1:0]  blink_period_ff, blink_period_in;
   logic [tsd_pkg::DIVIDER_WIDTH-1:0] refresh_count_ff, refresh_count_in;
   logic [tsd_pkg::PERIOD_WIDTH-1:0]  blink_count_ff, blink_count_in;
   logic                              blinking_ff, blinking_in;
   logic                              shown_ff, shown_in;
   logic [POS_WIDTH-1:0]              scan_position_ff, scan_position_in;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]   glyph_store_ff [DIGIT_COUNT];
   logic [tsd_pkg::GLYPH_WIDTH-1:0]   glyph_store_in [DIGIT_COUNT];
   logic [tsd_pkg::ENABLE_WIDTH-1:0]  enable_latch_ff, enable_latch_in;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]   segment_latch_ff, segment_latch_in;

   logic                  out_valid_ff, out_valid_in;
   tsd_pkg::result_type   out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   tsd_pkg::result_type   skid_data_ff, skid_data_in;

   tsd_pkg::glyph_set_type temp_glyphs;
   tsd_pkg::glyph_set_type new_glyphs;
   tsd_pkg::op_type        operation;
   tsd_pkg::mode_type      mode;
   tsd_pkg::result_type    result;
   logic                   accept;
   logic                   deliver;
   logic                   refresh_fire;
   logic [7:0]             onehot;

   tsd_temp_decode temp_decode (
      .temp_raw       (req.temp_raw),
      .low_resolution (req.low_resolution),
      .glyphs         (temp_glyphs)
   );

   assign req.ready = !skid_valid_ff;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign deliver   = out_valid_ff && rsp.ready;
   assign operation = tsd_pkg::op_type'(req.operation);
   assign mode      = tsd_pkg::mode_type'(req.display_mode);

   always_comb begin
      refresh_divider_in = refresh_divider_ff;
      blink_period_in    = blink_period_ff;
      if (csr.valid) begin
         unique case (csr.index)
            tsd_pkg::CSR_REFRESH_DIVIDER:
               refresh_divider_in = csr.data[tsd_pkg::DIVIDER_WIDTH-1:0];
            tsd_pkg::CSR_BLINK_PERIOD:
               blink_period_in = csr.data[tsd_pkg::PERIOD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      refresh_count_in = refresh_count_ff;
      blink_count_in   = blink_count_ff;
      blinking_in      = blinking_ff;
      shown_in         = shown_ff;
      scan_position_in = scan_position_ff;
      enable_latch_in  = enable_latch_ff;
      segment_latch_in = segment_latch_ff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         glyph_store_in[i] = glyph_store_ff[i];
      end
      refresh_fire = 1'b0;
      onehot       = 8'(1) << scan_position_ff;
      new_glyphs   = (operation == tsd_pkg::OP_TEMPERATURE) ? temp_glyphs
                   : {req.glyph_left, req.glyph_middle, req.glyph_right};

      if (accept) begin
         case (operation) inside
            tsd_pkg::OP_TICK: begin
               // The blink toggle lands before the refresh step looks at it.
               if (blinking_ff) begin
                  if (blink_count_ff == '0) begin
                     blink_count_in = blink_period_ff;
                     shown_in       = !shown_ff;
                  end else begin
                     blink_count_in = blink_count_ff - 1'b1;
                  end
               end
               if (refresh_count_ff != '0) begin
                  refresh_count_in = refresh_count_ff - 1'b1;
               end else begin
                  refresh_count_in = refresh_divider_ff;
                  refresh_fire     = 1'b1;
                  if (shown_in) begin
                     segment_latch_in = glyph_store_ff[scan_position_ff];
                     enable_latch_in  = onehot[tsd_pkg::ENABLE_WIDTH-1:0];
                     scan_position_in = (scan_position_ff == '0) ? LAST_POS
                                      : scan_position_ff - 1'b1;
                  end else begin
                     enable_latch_in = '0;
                  end
               end
            end
            tsd_pkg::OP_TEMPERATURE, tsd_pkg::OP_GLYPHS: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (i == 0) begin
                     glyph_store_in[i] = new_glyphs.left;
                  end else if (i == 1) begin
                     glyph_store_in[i] = new_glyphs.middle;
                  end else if (i == 2) begin
                     glyph_store_in[i] = new_glyphs.right;
                  end
               end
               case (mode)
                  tsd_pkg::MODE_BLINK: begin
                     blink_count_in = '0;
                     blinking_in    = 1'b1;
                     shown_in       = 1'b1;
                  end
                  tsd_pkg::MODE_STEADY: begin
                     blinking_in = 1'b0;
                     shown_in    = 1'b1;
                  end
                  tsd_pkg::MODE_DARK: begin
                     blinking_in = 1'b0;
                     shown_in    = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      result = '{enable_latch_in, segment_latch_in, shown_in};
   end

   // Output register with a skid register behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (deliver) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_divider_ff <= tsd_pkg::REFRESH_DIVIDER_RESET;
         blink_period_ff    <= tsd_pkg::BLINK_PERIOD_RESET;
         refresh_count_ff   <= '0;
         blink_count_ff     <= '0;
         blinking_ff        <= 1'b0;
         shown_ff           <= 1'b1;
         scan_position_ff   <= '0;
         enable_latch_ff    <= '0;
         segment_latch_ff   <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            glyph_store_ff[i] <= (i == 0) ? tsd_pkg::GLYPH_UNDERSCORE
                                          : tsd_pkg::GLYPH_BLANK;
         end
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         refresh_divider_ff <= refresh_divider_in;
         blink_period_ff    <= blink_period_in;
         refresh_count_ff   <= refresh_count_in;
         blink_count_ff     <= blink_count_in;
         blinking_ff        <= blinking_in;
         shown_ff           <= shown_in;
         scan_position_ff   <= scan_position_in;
         enable_latch_ff    <= enable_latch_in;
         segment_latch_ff   <= segment_latch_in;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            glyph_store_ff[i] <= glyph_store_in[i];
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.digit_enable  = out_data_ff.digit_enable;
   assign rsp.segment_glyph = out_data_ff.segment_glyph;
   assign rsp.visible       = out_data_ff.visible;

   `ASSERT_ALWAYS(skid_behind_output, clock, reset, !skid_valid_ff || out_valid_ff,
      "skid register holds a beat while the output register is empty")
   `ASSERT_ALWAYS(drive_onehot, clock, reset, $onehot0(enable_latch_ff),
      "more than one digit line driven")
   `ASSERT_ALWAYS(scan_in_range, clock, reset,
      32'(scan_position_ff) < 32'(DIGIT_COUNT), "scan position beyond last digit")
   `ASSERT_NEXT(dark_fire_blanks, clock, reset, refresh_fire && !shown_in,
      enable_latch_ff == '0, "refresh while dark left a digit driven")

endmodule

@@ design/tsd_temp_decode.sv @@
module tsd_temp_decode (
   input  logic signed [tsd_pkg::TEMP_WIDTH-1:0] temp_raw,
   input  logic                                  low_resolution,
   output tsd_pkg::glyph_set_type                glyphs
);

   logic [15:0] word;
   logic [15:0] inverted;
   logic [15:0] magnitude;
   logic        negative;
   logic [28:0] product;
   logic [8:0]  hundreds;
   logic [15:0] remainder_full;
   logic [7:0]  pair;
   logic [tsd_pkg::GLYPH_WIDTH-1:0] tens_glyph;
   logic [tsd_pkg::GLYPH_WIDTH-1:0] units_glyph;

   always_comb begin
      word     = temp_raw;
      negative = word[15];
      inverted = ~word;
      // Arithmetic shift of a negative word, then negate: ~x >> n, plus one.
      if (negative) begin
         magnitude = (low_resolution ? (inverted >> 1) : (inverted >> 4)) + 16'd1;
      end else begin
         magnitude = low_resolution ? (word >> 1) : (word >> 4);
      end

      // 5243 / 2^19 is close enough to 1/100 to be exact below 43699.
      product        = 29'(magnitude) * 29'd5243;
      hundreds       = product[27:19];
      remainder_full = magnitude - 16'(hundreds) * 16'd100;
      pair           = tsd_pkg::DIGIT_PAIRS[remainder_full[6:0]];
      tens_glyph     = {1'b0, pair[7:4]};
      units_glyph    = {1'b0, pair[3:0]};

      if (magnitude >= 16'd100) begin
         glyphs = '{tsd_pkg::GLYPH_ONE, tens_glyph, units_glyph};
      end else if (magnitude >= 16'd10) begin
         if (negative) begin
            glyphs = '{tsd_pkg::GLYPH_MINUS, tens_glyph, units_glyph};
         end else begin
            glyphs = '{tens_glyph, units_glyph, tsd_pkg::GLYPH_DEGREE};
         end
      end else if (negative) begin
         glyphs = '{tsd_pkg::GLYPH_MINUS, units_glyph, tsd_pkg::GLYPH_DEGREE};
      end else begin
         glyphs = '{tsd_pkg::GLYPH_BLANK, units_glyph, tsd_pkg::GLYPH_DEGREE};
      end
   end

endmodule

@@ dv/tb_temperature_seven_segment_display.sv @@
`timescale 1ns / 100ps

module tb_temperature_seven_segment_display;

   localparam int DIGIT_COUNT = 3;
   localparam int PHASES = 5;
   localparam int DIRECTED_COUNT = 25;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [tsd_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'd15;

   localparam int PHASE_DIVIDER [PHASES] = '{0, 255, 2, 1, 0};
   localparam int PHASE_PERIOD  [PHASES] = '{0, 65535, 7, 300, 5};
   localparam int PHASE_ITEMS   [PHASES] = '{140, 120, 160, 140, 140};

   typedef struct packed {
      logic [1:0]                     op;
      logic [tsd_pkg::TEMP_WIDTH-1:0] temp_raw;
      logic                           low_res;
      tsd_pkg::glyph_set_type         glyphs;
      logic [1:0]                     mode;
   } display_cmd_type;

   typedef struct packed {
      display_cmd_type     cmd;
      logic                typed;
      tsd_pkg::result_type want;
   } directed_row_type;

   // The divider is 0 and the blink period 3 while these rows run.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b1, '{3'b001, tsd_pkg::GLYPH_UNDERSCORE, 1'b1}},
      '{'{tsd_pkg::OP_TICK, 16'hFFFF, 1'b1, '{5'd31, 5'd31, 5'd31}, tsd_pkg::MODE_KEEP},
        1'b1, '{3'b100, tsd_pkg::GLYPH_BLANK, 1'b1}},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b1, '{3'b010, tsd_pkg::GLYPH_BLANK, 1'b1}},
      '{'{tsd_pkg::OP_GLYPHS, 16'h0000, 1'b0, '{5'd31, 5'd0, 5'd31}, tsd_pkg::MODE_STEADY},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h7FFF, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h8000, 1'b1, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'hFFFF, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h0000, 1'b1, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h0190, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'hFE70, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h00C6, 1'b1, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h0640, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'hF9C0, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'hFF70, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h0013, 1'b1, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_GLYPHS, 16'h0000, 1'b0, '{5'd0, 5'd31, 5'd0}, tsd_pkg::MODE_DARK},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{OP_UNUSED, 16'hFFFF, 1'b1, '{5'd31, 5'd31, 5'd31}, tsd_pkg::MODE_BLINK},
        1'b0, '0},
      '{'{tsd_pkg::OP_TEMPERATURE, 16'h8000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_BLINK},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_TICK, 16'h0000, 1'b0, '{5'd0, 5'd0, 5'd0}, tsd_pkg::MODE_KEEP},
        1'b0, '0},
      '{'{tsd_pkg::OP_GLYPHS, 16'h0000, 1'b0, '{5'd21, 5'd10, 5'd5}, tsd_pkg::MODE_KEEP},
        1'b0, '0}
   };

   logic clock;
   logic reset;

   tsd_req_if req_chan ();
   tsd_rsp_if rsp_chan ();
   tsd_csr_if csr_chan ();

   temperature_seven_segment_display #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .rsp(rsp_chan),
      .csr(csr_chan)
   );

   // Shadow copy of the display state and its two registers.
   logic [tsd_pkg::DIVIDER_WIDTH-1:0] divider_cfg;
   logic [tsd_pkg::PERIOD_WIDTH-1:0]  period_cfg;
   logic [tsd_pkg::DIVIDER_WIDTH-1:0] refresh_left;
   logic [tsd_pkg::PERIOD_WIDTH-1:0]  blink_left;
   logic                              blink_on;
   logic                              lit;
   logic [1:0]                        scan_pos;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]   glyph_mem [DIGIT_COUNT];
   logic [tsd_pkg::ENABLE_WIDTH-1:0]  drive_lines;
   logic [tsd_pkg::GLYPH_WIDTH-1:0]   segment_now;

   tsd_pkg::result_type pending_display [$];
   int                  mismatch_count = 0;
   bit                  idling_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic tsd_pkg::glyph_set_type temperature_glyphs(
         logic [tsd_pkg::TEMP_WIDTH-1:0] raw, logic low_res);
      int unsigned                    shift;
      int unsigned                    mag;
      int unsigned                    tens;
      int unsigned                    units;
      logic [tsd_pkg::TEMP_WIDTH-1:0] inv;
      tsd_pkg::glyph_set_type         g;
      shift = low_res ? 1 : 4;
      // An arithmetic shift of a negative word, taken as a magnitude.
      if (raw[tsd_pkg::TEMP_WIDTH-1]) begin
         inv = ~raw;
         mag = (inv >> shift) + 1;
      end else begin
         mag = raw >> shift;
      end
      units = mag % 10;
      tens  = (mag / 10) % 10;
      if (mag >= 100) begin
         g = {tsd_pkg::GLYPH_ONE, 5'(tens), 5'(units)};
      end else if (mag >= 10) begin
         g = raw[tsd_pkg::TEMP_WIDTH-1] ? {tsd_pkg::GLYPH_MINUS, 5'(tens), 5'(units)}
                                        : {5'(tens), 5'(units), tsd_pkg::GLYPH_DEGREE};
      end else begin
         g = raw[tsd_pkg::TEMP_WIDTH-1]
           ? {tsd_pkg::GLYPH_MINUS, 5'(units), tsd_pkg::GLYPH_DEGREE}
           : {tsd_pkg::GLYPH_BLANK, 5'(units), tsd_pkg::GLYPH_DEGREE};
      end
      return g;
   endfunction

   task automatic advance_display(input display_cmd_type cmd,
                                  output tsd_pkg::result_type r);
      tsd_pkg::glyph_set_type g;
      logic [1:0]             pos;
      g = cmd.glyphs;
      case (cmd.op) inside
         tsd_pkg::OP_TICK: begin
            if (blink_on) begin
               if (blink_left == '0) begin
                  blink_left = period_cfg;
                  lit = !lit;
               end else begin
                  blink_left = blink_left - 1'b1;
               end
            end
            if (refresh_left != '0) begin
               refresh_left = refresh_left - 1'b1;
            end else begin
               refresh_left = divider_cfg;
               if (lit) begin
                  pos = (scan_pos >= DIGIT_COUNT) ? 2'd0 : scan_pos;
                  segment_now = glyph_mem[pos];
                  drive_lines = 3'(1 << pos);
                  scan_pos = (pos == 2'd0) ? 2'(DIGIT_COUNT - 1) : pos - 1'b1;
               end else begin
                  drive_lines = '0;
               end
            end
         end
         tsd_pkg::OP_TEMPERATURE, tsd_pkg::OP_GLYPHS: begin
            if (cmd.op == tsd_pkg::OP_TEMPERATURE) begin
               g = temperature_glyphs(cmd.temp_raw, cmd.low_res);
            end
            glyph_mem[0] = g.left;
            glyph_mem[1] = g.middle;
            glyph_mem[2] = g.right;
            case (cmd.mode)
               tsd_pkg::MODE_BLINK: begin
                  blink_left = '0;
                  blink_on = 1'b1;
                  lit = 1'b1;
               end
               tsd_pkg::MODE_STEADY: begin
                  blink_on = 1'b0;
                  lit = 1'b1;
               end
               tsd_pkg::MODE_DARK: begin
                  blink_on = 1'b0;
                  lit = 1'b0;
               end
               default: ;
            endcase
         end
         // The unused code leaves every bit of state alone.
         default: ;
      endcase
      r = '{drive_lines, segment_now, lit};
   endtask

   function automatic display_cmd_type random_cmd();
      display_cmd_type cmd;
      int unsigned     pick;
      int unsigned     shift;
      int unsigned     mag;
      cmd.temp_raw = 16'($urandom);
      cmd.low_res  = 1'($urandom_range(0, 1));
      cmd.glyphs   = '{5'($urandom), 5'($urandom), 5'($urandom)};
      cmd.mode     = ($urandom_range(0, 4) == 4) ? 2'(tsd_pkg::MODE_KEEP)
                                                 : 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         cmd.op = tsd_pkg::OP_TICK;
      end else if (pick < 75) begin
         cmd.op = tsd_pkg::OP_TEMPERATURE;
         shift = cmd.low_res ? 1 : 4;
         // Most words land on chosen magnitude ranges, the rest are raw noise.
         case ($urandom_range(0, 3))
            0: mag = $urandom_range(0, 9);
            1: mag = $urandom_range(10, 99);
            2: mag = $urandom_range(100, 199);
            default: mag = 0;
         endcase
         if (mag != 0 || $urandom_range(0, 3) == 0) begin
            cmd.temp_raw = 16'(mag << shift) | 16'($urandom_range(0, (1 << shift) - 1));
            if ($urandom_range(0, 1) == 1) cmd.temp_raw = -cmd.temp_raw;
         end
      end else if (pick < 94) begin
         cmd.op = tsd_pkg::OP_GLYPHS;
      end else begin
         cmd.op = OP_UNUSED;
      end
      return cmd;
   endfunction

   task automatic send_cmd(input display_cmd_type cmd, input logic typed,
                           input tsd_pkg::result_type want);
      tsd_pkg::result_type predicted;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= cmd.op;
      req_chan.temp_raw       <= cmd.temp_raw;
      req_chan.low_resolution <= cmd.low_res;
      req_chan.glyph_left     <= cmd.glyphs.left;
      req_chan.glyph_middle   <= cmd.glyphs.middle;
      req_chan.glyph_right    <= cmd.glyphs.right;
      req_chan.display_mode   <= cmd.mode;
      do @(posedge clock); while (!req_chan.ready);
      advance_display(cmd, predicted);
      pending_display.push_back(typed ? want : predicted);
   endtask

   // The caller lowers csr valid after its last write.
   task automatic write_register(input logic [tsd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [tsd_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         tsd_pkg::CSR_REFRESH_DIVIDER: divider_cfg = value[tsd_pkg::DIVIDER_WIDTH-1:0];
         tsd_pkg::CSR_BLINK_PERIOD:    period_cfg = value;
         default: ;
      endcase
   endtask

   task automatic settle_display();
      req_chan.valid <= 1'b0;
      while (pending_display.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tsd_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_display.size() == 0) begin
            mismatch_count++;
            $display("%0t: beat with nothing expected, actual enable %0d glyph %0d visible %0d",
                     $time, rsp_chan.digit_enable, rsp_chan.segment_glyph, rsp_chan.visible);
         end else begin
            want = pending_display.pop_front();
            report_field("digit_enable", want.digit_enable, rsp_chan.digit_enable);
            report_field("segment_glyph", want.segment_glyph, rsp_chan.segment_glyph);
            report_field("visible", want.visible, rsp_chan.visible);
         end
      end
   end

   // Receiver stalls come in bursts while idling is on, with stretches of steady readiness between.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24))
            @(posedge clock);
         if (idling_on) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.operation      <= '0;
      req_chan.temp_raw       <= '0;
      req_chan.low_resolution <= 1'b0;
      req_chan.glyph_left     <= '0;
      req_chan.glyph_middle   <= '0;
      req_chan.glyph_right    <= '0;
      req_chan.display_mode   <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.data           <= '0;
      divider_cfg  = tsd_pkg::REFRESH_DIVIDER_RESET;
      period_cfg   = tsd_pkg::BLINK_PERIOD_RESET;
      refresh_left = '0;
      blink_left   = '0;
      blink_on     = 1'b0;
      lit          = 1'b1;
      scan_pos     = '0;
      glyph_mem    = '{tsd_pkg::GLYPH_UNDERSCORE, tsd_pkg::GLYPH_BLANK, tsd_pkg::GLYPH_BLANK};
      drive_lines  = '0;
      segment_now  = '0;
      idling_on    = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_register(tsd_pkg::CSR_REFRESH_DIVIDER, {8'($urandom), 8'd0});
      write_register(tsd_pkg::CSR_BLINK_PERIOD, 16'd3);
      write_register(CSR_UNUSED_INDEX, 16'($urandom));
      csr_chan.valid <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle_display();
         if (ph == PHASES - 1) idling_on = 1'b0;
         write_register(tsd_pkg::CSR_REFRESH_DIVIDER, {8'($urandom), 8'(PHASE_DIVIDER[ph])});
         write_register(tsd_pkg::CSR_BLINK_PERIOD, 16'(PHASE_PERIOD[ph]));
         csr_chan.valid <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
            // Once in the run the sender holds off until the display has caught up.
            if (ph == 2 && n == 80) settle_display();
            send_cmd(random_cmd(), 1'b0, '0);
         end
      end

      settle_display();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
